FILE: rtl/sha_pkg.sv
// package for the sha-256 stream hasher: constants, types and round functions
// used by sha_sched_mem, sha_round_core and sha256_stream_hasher_unit
// no dependencies
package sha_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned SlotW  = 4;
  localparam int unsigned RoundW = 6;
  localparam logic [7:0]  PadMark = 8'h80;
  localparam logic [SlotW-1:0] LenSlot = 4'd14;

  typedef logic [WordW-1:0] word_t;

  typedef enum logic [2:0] {
    StIdle,
    StPad,
    StInit,
    StRound,
    StFold,
    StEmit
  } state_e;

  // request from the sequencer to the compression core
  typedef struct packed {
    logic start;        // load working vars from chain
    logic step;         // one round with given schedule word
    logic fold;         // add working vars into chain
    logic reset_chain;  // back to initial values
  } core_ctl_t;

  function automatic word_t init_hash(input logic [2:0] i);
    case (i)
      3'd0: init_hash = 32'h6a09e667;
      3'd1: init_hash = 32'hbb67ae85;
      3'd2: init_hash = 32'h3c6ef372;
      3'd3: init_hash = 32'ha54ff53a;
      3'd4: init_hash = 32'h510e527f;
      3'd5: init_hash = 32'h9b05688c;
      3'd6: init_hash = 32'h1f83d9ab;
      default: init_hash = 32'h5be0cd19;
    endcase
  endfunction

  function automatic word_t round_k(input logic [RoundW-1:0] t);
    word_t k [64];
    k = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    round_k = k[t];
  endfunction

  function automatic word_t rotr(input word_t x, input int unsigned n);
    rotr = (x >> n) | (x << (WordW - n));
  endfunction

endpackage

FILE: rtl/sha_sched_mem.sv
// message schedule window: 16 x 32 synchronous memory, one write port,
// two read ports with registered data; uses sha_pkg
module sha_sched_mem
  import sha_pkg::*;
(
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [SlotW-1:0] waddr_i,
  input  word_t            wdata_i,
  input  logic [SlotW-1:0] raddr_a_i,
  input  logic [SlotW-1:0] raddr_b_i,
  output word_t            rdata_a_o,
  output word_t            rdata_b_o
);

  word_t mem [16];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule

FILE: rtl/sha_round_core.sv
// sha-256 round unit with working variables and chaining value registers
// depends on sha_pkg
module sha_round_core
  import sha_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  core_ctl_t         ctl_i,
  input  word_t             w_i,
  input  logic [RoundW-1:0] round_i,
  input  logic [2:0]        rd_idx_i,
  output word_t             chain_o
);

  word_t v_q [8];
  word_t v_d [8];
  word_t h_q [8];
  word_t h_d [8];
  word_t t1, t2;

  always_comb begin
    t1 = v_q[7] + (rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25))
       + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6])) + round_k(round_i) + w_i;
    t2 = (rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22))
       + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
    v_d = v_q;
    h_d = h_q;
    if (ctl_i.start) begin
      v_d = h_q;
    end else if (ctl_i.step) begin
      v_d[7] = v_q[6];
      v_d[6] = v_q[5];
      v_d[5] = v_q[4];
      v_d[4] = v_q[3] + t1;
      v_d[3] = v_q[2];
      v_d[2] = v_q[1];
      v_d[1] = v_q[0];
      v_d[0] = t1 + t2;
    end
    if (ctl_i.reset_chain) begin
      for (int i = 0; i < 8; i++) h_d[i] = init_hash(3'(i));
    end else if (ctl_i.fold) begin
      for (int i = 0; i < 8; i++) h_d[i] = h_q[i] + v_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    v_q <= v_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) h_q[i] <= init_hash(3'(i));
    end else begin
      h_q <= h_d;
    end
  end

  assign chain_o = h_q[rd_idx_i];

  property p_excl;
    @(posedge clk_i) disable iff (!rst_ni)
      !(ctl_i.start && ctl_i.step);
  endproperty
  a_excl: assert property (p_excl) else $error("start and step together");

  a_fold_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
      !(ctl_i.fold && ctl_i.reset_chain)) else $error("fold and chain reset together");

  a_reset_val: assert property (@(posedge clk_i) disable iff (!rst_ni)
      ctl_i.reset_chain |=> h_q[0] == 32'h6a09e667) else $error("chain not reloaded");

endmodule

FILE: rtl/sha256_stream_hasher_unit.sv
// top level of the sha-256 stream hasher: word intake, padding and round sequencer
// depends on sha_pkg, sha_sched_mem and sha_round_core
//
//  channel | dir | tdata                         | tuser        | tlast
//  s_axis  | in  | [31:0] data_word              | [2:0] valid_bytes | last_word
//  m_axis  | out | [31:0] digest_word            | [2:0] digest_index | digest_last
//
// message words are taken one per cycle while s_axis_tready is high; every 16th
// word starts a compression (one load, the rounds on the single round unit with the
// schedule window read from a two-port memory, one fold)
// the last word adds padding words at one per cycle, one or two compressions,
// then eight digest beats held in an output register until taken
// reset (rst_ni low) loads the initial hash, clears length and slot counters
// s_axis_tready is low while padding, compressing or emitting
module sha256_stream_hasher_unit
  import sha_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] data_word
  input  logic [2:0]  s_axis_tuser,   // [2:0] valid_bytes
  input  logic        s_axis_tlast,   // last_word
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] digest_word
  output logic [2:0]  m_axis_tuser,   // [2:0] digest_index
  output logic        m_axis_tlast    // digest_last
);

  state_e state_q, state_d;
  logic [SlotW-1:0]  pos_q, pos_d;       // next free slot
  logic [63:0]       len_q, len_d;       // message bit length
  logic [RoundW-1:0] rnd_q, rnd_d;
  logic              fin_q, fin_d;       // pad mark written
  logic              lenw_q, lenw_d;     // length words belong to this block
  logic              lst_q, lst_d;       // last word taken, message closing
  logic [2:0]        idx_q, idx_d;
  logic              ov_q, ov_d;         // output beat pending
  word_t             od_q;
  logic [2:0]        oi_q;

  logic              we;
  logic [SlotW-1:0]  waddr;
  word_t             wdata;
  logic [SlotW-1:0]  ra, rb;
  word_t             rda, rdb;
  word_t             w_round;
  core_ctl_t         ctl;
  word_t             chain;
  logic [2:0]        vb;
  word_t             keep, in_word;
  logic              accept;

  // rolling window: memory read of round t+1 issued during round t
  word_t             wm2_q, wm7_q;
  logic [SlotW-1:0]  rnext;

  sha_sched_mem u_mem (
    .clk_i    (clk_i),
    .we_i     (we),
    .waddr_i  (waddr),
    .wdata_i  (wdata),
    .raddr_a_i(ra),
    .raddr_b_i(rb),
    .rdata_a_o(rda),
    .rdata_b_o(rdb)
  );

  sha_round_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl),
    .w_i     (w_round),
    .round_i (rnd_q),
    .rd_idx_i(idx_q),
    .chain_o (chain)
  );

  assign accept = s_axis_tvalid && s_axis_tready;
  assign vb     = (s_axis_tuser > 3'd4) ? 3'd4 : s_axis_tuser;

  always_comb begin
    case (vb)
      3'd0:    keep = 32'h0000_0000;
      3'd1:    keep = 32'hff00_0000;
      3'd2:    keep = 32'hffff_0000;
      3'd3:    keep = 32'hffff_ff00;
      default: keep = 32'hffff_ffff;
    endcase
    in_word = (s_axis_tdata & keep) | (word_t'(PadMark) << (5'd24 - {vb[1:0], 3'b000}));
    if (vb == 3'd4) in_word = s_axis_tdata;
  end

  // schedule word for the current round: read data a = w[t&15], read data b =
  // w[t-15], other neighbours from the window copy; for t>=16 the new w is
  // computed and written back
  always_comb begin
    word_t a, b;
    a = rdb;
    b = wm2_q;
    if (rnd_q < 6'd16) begin
      w_round = rda;
    end else begin
      w_round = rda + (rotr(a, 7) ^ rotr(a, 18) ^ (a >> 3)) + wm7_q
              + (rotr(b, 17) ^ rotr(b, 19) ^ (b >> 10));
    end
  end

  // one memory port carries w[t-15] ahead of round t, the other w[t&15]
  assign rnext = rnd_d[SlotW-1:0];

  always_comb begin
    state_d = state_q;
    pos_d   = pos_q;
    len_d   = len_q;
    rnd_d   = rnd_q;
    fin_d   = fin_q;
    lenw_d  = lenw_q;
    lst_d   = lst_q;
    idx_d   = idx_q;
    ov_d    = ov_q;
    we      = 1'b0;
    waddr   = pos_q;
    wdata   = '0;
    ctl     = '0;
    s_axis_tready = 1'b0;
    ra      = rnext;
    rb      = rnext - 4'd15 + 4'd0;
    if (ov_q && m_axis_tready) ov_d = 1'b0;

    case (state_q)
      StIdle: begin
        s_axis_tready = 1'b1;
        if (accept) begin
          we    = 1'b1;
          pos_d = pos_q + 4'd1;
          if (!s_axis_tlast) begin
            wdata = s_axis_tdata;
            len_d = len_q + 64'd32;
            if (pos_q == 4'd15) state_d = StInit;
          end else begin
            len_d  = len_q + 64'({vb, 3'b000});
            fin_d  = 1'b1;
            wdata  = in_word;
            lenw_d = 1'b0;
            lst_d  = 1'b1;
            // full last word: the pad mark goes into the following slot
            state_d = (pos_q == 4'd15) ? StInit : StPad;
            if (vb == 3'd4) begin
              fin_d = 1'b0;
            end
          end
        end
      end
      StPad: begin
        // fin_q low: emit the pad-mark word first
        we    = 1'b1;
        pos_d = pos_q + 4'd1;
        if (!fin_q) begin
          wdata = word_t'(PadMark) << 24;
          fin_d = 1'b1;
        end else if (pos_q == LenSlot) begin
          wdata  = len_q[63:32];
          lenw_d = 1'b1;
        end else if (pos_q == 4'd15 && lenw_q) begin
          wdata = len_q[31:0];
        end else begin
          wdata = '0;
        end
        if (pos_q == 4'd15) state_d = StInit;
      end
      StInit: begin
        ctl.start = 1'b1;
        rnd_d     = '0;
        state_d   = StRound;
      end
      StRound: begin
        ctl.step = 1'b1;
        rnd_d    = rnd_q + 6'd1;
        if (rnd_q >= 6'd16) begin
          we    = 1'b1;
          waddr = rnd_q[SlotW-1:0];
          wdata = w_round;
        end
        if (rnd_q == 6'd63) state_d = StFold;
      end
      StFold: begin
        ctl.fold = 1'b1;
        if (fin_q && lenw_q) begin
          state_d = StEmit;
          idx_d   = '0;
        end else if (lst_q) begin
          state_d = StPad;
        end else begin
          state_d = StIdle;
        end
      end
      StEmit: begin
        if (!ov_q || m_axis_tready) begin
          ov_d  = 1'b1;
          idx_d = idx_q + 3'd1;
          if (idx_q == 3'd7) begin
            ctl.reset_chain = 1'b1;
            len_d   = '0;
            pos_d   = '0;
            fin_d   = 1'b0;
            lenw_d  = 1'b0;
            lst_d   = 1'b0;
            state_d = StIdle;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // output register, one beat at a time
  always_ff @(posedge clk_i) begin
    if (state_q == StEmit && (!ov_q || m_axis_tready)) begin
      od_q <= chain;
      oi_q <= idx_q;
    end
  end

  // copy of the window for the neighbours w[t-2] and w[t-7]
  word_t wwin_q [16];
  always_ff @(posedge clk_i) begin
    if (we) wwin_q[waddr] <= wdata;
  end
  always_comb begin
    logic [SlotW-1:0] t4;
    t4 = rnd_q[SlotW-1:0];
    wm2_q  = (t4 - 4'd2  == waddr && we) ? wdata : wwin_q[4'(t4 - 4'd2)];
    wm7_q  = wwin_q[4'(t4 - 4'd7)];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      pos_q   <= '0;
      len_q   <= '0;
      rnd_q   <= '0;
      fin_q   <= 1'b0;
      lenw_q  <= 1'b0;
      lst_q   <= 1'b0;
      idx_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      len_q   <= len_d;
      rnd_q   <= rnd_d;
      fin_q   <= fin_d;
      lenw_q  <= lenw_d;
      lst_q   <= lst_d;
      idx_q   <= idx_d;
      ov_q    <= ov_d;
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = od_q;
  assign m_axis_tuser  = oi_q;
  assign m_axis_tlast  = (oi_q == 3'd7);

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
      s_axis_tready |-> state_q == StIdle) else $error("ready outside idle");

  a_round_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (state_q == StRound && rnd_q == 6'd63) |=> state_q == StFold)
      else $error("round count lost");

  a_emit_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
      state_q == StEmit |-> (fin_q && lenw_q)) else $error("digest without length");

  a_pad_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (state_q == StInit) |-> pos_q == 4'd0) else $error("block started unfilled");

endmodule
